// File: rtl/clock_frame_victim_select_macros.svh
// ----------------------------------------------------------------------------
// Clock frame victim select - assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef CLOCK_FRAME_VICTIM_SELECT_MACROS_SVH
`define CLOCK_FRAME_VICTIM_SELECT_MACROS_SVH

// same-cycle property
`define CFVS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent now, consequent in the next cycle
`define CFVS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/cfvs_pkg.sv
// ----------------------------------------------------------------------------
// cfvs_pkg
// Types and constants shared by the clock frame victim select block.
// ----------------------------------------------------------------------------
package cfvs_pkg;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned FRAME_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_FIND    = 3'd0,
    OP_ACCESS  = 3'd1,
    OP_FILL    = 3'd2,
    OP_RELEASE = 3'd3,
    OP_CLEAN   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_FREE     = 2'd0,
    ST_INUSE    = 2'd1,
    ST_RESERVED = 2'd2
  } status_e;

  typedef struct packed {
    status_e status;
    logic    owned;
    logic    used;
    logic    dirty;
  } entry_t;

  // free sweep, then two pairs of clean/dirty sweeps
  localparam logic [2:0] SWEEP_FREE = 3'd0;
  localparam logic [2:0] SWEEP_LAST = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE    = 2'd0,
    S_OP_EXEC = 2'd1,
    S_FIND    = 2'd2
  } state_e;

  typedef struct packed {
    logic accept;
    logic op_exec;
    logic find_step;
  } dp_cmd_t;

  typedef struct packed {
    logic req_find;
    logic find_done;
  } dp_status_t;

endpackage

// File: rtl/clock_frame_victim_select.sv
// ----------------------------------------------------------------------------
// clock_frame_victim_select
// Frame table with an enhanced second-chance clock hand: picks a victim
// frame and applies access, fill, release and clean updates.
// ----------------------------------------------------------------------------
//  channel  | handshake            | word
//  ---------+----------------------+-----------------------------------------
//  request  | start / busy         | opcode_i, frame_i, is_write_i
//  result   | valid_o (one cycle)  | victim_frame_o, found_o, write_back_o
//
//  A word is taken when start is high and busy low; busy then stays
//  high until the result cycle, when valid_o pulses and busy drops.
//  Access, fill, release, clean and unused opcodes: busy in the execute
//  state only, result registered after it. Find: busy through the sweep,
//  one frame per cycle through the frame table RAM read port.
//  Reset clears the hand and the per-frame valid bits; no clearing pass.
//  The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module clock_frame_victim_select #(
  parameter int unsigned FRAMES = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] opcode_i,
  input  logic [4:0] frame_i,
  input  logic       is_write_i,
  output logic       valid_o,
  output logic [4:0] victim_frame_o,
  output logic       found_o,
  output logic       write_back_o
);

  cfvs_pkg::dp_cmd_t    cmd;
  cfvs_pkg::dp_status_t status;

  cfvs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .busy_o   (busy),
    .cmd_o    (cmd),
    .status_i (status)
  );

  cfvs_dp #(
    .FRAMES (FRAMES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .opcode_i       (opcode_i),
    .frame_i        (frame_i),
    .is_write_i     (is_write_i),
    .valid_o        (valid_o),
    .victim_frame_o (victim_frame_o),
    .found_o        (found_o),
    .write_back_o   (write_back_o)
  );

endmodule

// File: rtl/cfvs_ram.sv
// ----------------------------------------------------------------------------
// cfvs_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cfvs_ram #(
  parameter int unsigned WIDTH = 5,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/cfvs_ctrl.sv
// ----------------------------------------------------------------------------
// cfvs_ctrl
// Sequencer: takes a word, runs one table update or a clock sweep.
// ----------------------------------------------------------------------------
module cfvs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  output cfvs_pkg::dp_cmd_t   cmd_o,
  input  cfvs_pkg::dp_status_t status_i
);

  cfvs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cfvs_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cfvs_pkg::S_IDLE: begin
        if (start_i) begin
          state_d = status_i.req_find ? cfvs_pkg::S_FIND : cfvs_pkg::S_OP_EXEC;
        end
      end
      cfvs_pkg::S_OP_EXEC: begin
        state_d = cfvs_pkg::S_IDLE;
      end
      cfvs_pkg::S_FIND: begin
        if (status_i.find_done) begin
          state_d = cfvs_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = cfvs_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    unique case (state_q)
      cfvs_pkg::S_IDLE: begin
        busy_o       = 1'b0;
        cmd_o.accept = start_i;
      end
      cfvs_pkg::S_OP_EXEC: begin
        cmd_o.op_exec = 1'b1;
      end
      cfvs_pkg::S_FIND: begin
        cmd_o.find_step = 1'b1;
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

endmodule

// File: rtl/cfvs_dp.sv
// ----------------------------------------------------------------------------
// cfvs_dp
// Frame table, clock hand and sweep pipeline (read one frame, judge it).
// ----------------------------------------------------------------------------
module cfvs_dp #(
  parameter int unsigned FRAMES = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cfvs_pkg::dp_cmd_t      cmd_i,
  output cfvs_pkg::dp_status_t   status_o,
  input  logic [cfvs_pkg::OP_W-1:0]    opcode_i,
  input  logic [cfvs_pkg::FRAME_W-1:0] frame_i,
  input  logic                   is_write_i,
  output logic                   valid_o,
  output logic [cfvs_pkg::FRAME_W-1:0] victim_frame_o,
  output logic                   found_o,
  output logic                   write_back_o
);

  localparam int unsigned AW = $clog2(FRAMES);
  localparam int unsigned NW = $clog2(FRAMES + 1);
  localparam int unsigned EW = $bits(cfvs_pkg::entry_t);

  logic [AW-1:0] hand_q;
  logic [AW-1:0] start_q;
  logic [AW-1:0] ev_addr_q;
  logic [2:0]    ev_sweep_q;
  logic [NW-1:0] ev_n_q;
  cfvs_pkg::op_e op_q;
  logic [cfvs_pkg::FRAME_W-1:0] frame_q;
  logic          wr_q;
  logic [FRAMES-1:0] valid_q;
  logic          rd_valid_q;
  logic          res_valid_q;
  logic [cfvs_pkg::FRAME_W-1:0] res_victim_q;
  logic          res_found_q;
  logic          res_wb_q;

  logic [AW-1:0] hand_inc, ev_inc, raddr, waddr, op_addr;
  logic [EW-1:0] rdata;
  logic          we;
  cfvs_pkg::entry_t entry, wdata;
  logic          in_range, req_find;
  logic          kind_free, kind_clean, kind_dirty;
  logic          skip, match, hit, last_step, find_done, res_load;
  logic [cfvs_pkg::FRAME_W-1:0] victim_d;
  logic          found_d, wb_d;

  assign hand_inc = (hand_q == AW'(FRAMES - 1)) ? '0 : hand_q + 1'b1;
  assign ev_inc   = (ev_addr_q == AW'(FRAMES - 1)) ? '0 : ev_addr_q + 1'b1;
  assign req_find = (cfvs_pkg::op_e'(opcode_i) == cfvs_pkg::OP_FIND);

  assign raddr = cmd_i.accept ? (req_find ? hand_inc : AW'(frame_i)) : ev_inc;

  cfvs_ram #(
    .WIDTH (EW),
    .DEPTH (FRAMES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // never-written frames read as free and clear
  assign entry = rd_valid_q ? cfvs_pkg::entry_t'(rdata) : '0;

  assign op_addr  = AW'(frame_q);
  assign in_range = (32'(frame_q) < 32'(FRAMES));

  assign kind_free  = (ev_sweep_q == cfvs_pkg::SWEEP_FREE);
  assign kind_clean = ev_sweep_q[0];
  assign kind_dirty = !kind_free && !ev_sweep_q[0];

  assign skip  = (ev_addr_q == start_q);
  assign match = kind_free ? (entry.status == cfvs_pkg::ST_FREE)
               : (!entry.owned ||
                  ((entry.status != cfvs_pkg::ST_RESERVED) && entry.used &&
                   ((kind_clean && !entry.dirty) || (kind_dirty && entry.dirty))));
  assign hit       = !skip && match;
  assign last_step = (ev_sweep_q == cfvs_pkg::SWEEP_LAST) && (ev_n_q == NW'(FRAMES));
  assign find_done = hit || last_step;

  assign status_o.req_find  = req_find;
  assign status_o.find_done = find_done;

  always_comb begin
    we       = 1'b0;
    waddr    = ev_addr_q;
    wdata    = entry;
    victim_d = '0;
    found_d  = 1'b0;
    wb_d     = 1'b0;
    if (cmd_i.find_step) begin
      if (hit) begin
        we           = 1'b1;
        wdata.status = cfvs_pkg::ST_RESERVED;
        victim_d     = cfvs_pkg::FRAME_W'(ev_addr_q);
        found_d      = 1'b1;
        wb_d         = entry.owned && entry.dirty;
      end else if (!skip && kind_dirty && entry.owned) begin
        we         = 1'b1;
        wdata.used = 1'b1;
      end
    end else if (cmd_i.op_exec && in_range) begin
      waddr = op_addr;
      case (op_q)
        cfvs_pkg::OP_ACCESS: begin
          we          = 1'b1;
          wdata.used  = 1'b0;
          wdata.dirty = entry.dirty || wr_q;
          found_d     = 1'b1;
        end
        cfvs_pkg::OP_FILL: begin
          we      = 1'b1;
          wdata   = '{status: cfvs_pkg::ST_INUSE, owned: 1'b1, used: 1'b0, dirty: 1'b0};
          found_d = 1'b1;
        end
        cfvs_pkg::OP_RELEASE: begin
          if (entry.status != cfvs_pkg::ST_RESERVED) begin
            we      = 1'b1;
            wdata   = '0;
            found_d = 1'b1;
          end
        end
        cfvs_pkg::OP_CLEAN: begin
          we          = 1'b1;
          wdata.dirty = 1'b0;
          found_d     = 1'b1;
          wb_d        = entry.owned && entry.dirty;
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end
  end

  assign res_load = cmd_i.op_exec || (cmd_i.find_step && find_done);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hand_q       <= '0;
      valid_q      <= '0;
      rd_valid_q   <= 1'b0;
      res_valid_q  <= 1'b0;
      res_victim_q <= '0;
      res_found_q  <= 1'b0;
      res_wb_q     <= 1'b0;
    end else begin
      rd_valid_q  <= valid_q[raddr];
      res_valid_q <= res_load;
      if (we) begin
        valid_q[waddr] <= 1'b1;
      end
      if (cmd_i.find_step) begin
        hand_q <= ev_addr_q;
      end
      if (res_load) begin
        res_victim_q <= victim_d;
        res_found_q  <= found_d;
        res_wb_q     <= wb_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q       <= cfvs_pkg::op_e'(opcode_i);
      frame_q    <= frame_i;
      wr_q       <= is_write_i;
      start_q    <= hand_q;
      ev_addr_q  <= hand_inc;
      ev_sweep_q <= cfvs_pkg::SWEEP_FREE;
      ev_n_q     <= '0;
    end else if (cmd_i.find_step) begin
      ev_addr_q <= ev_inc;
      if (ev_n_q == NW'(FRAMES)) begin
        ev_n_q     <= '0;
        ev_sweep_q <= ev_sweep_q + 3'd1;
      end else begin
        ev_n_q <= ev_n_q + 1'b1;
      end
    end
  end

  assign valid_o        = res_valid_q;
  assign victim_frame_o = res_victim_q;
  assign found_o        = res_found_q;
  assign write_back_o   = res_wb_q;

endmodule

// File: rtl/cfvs_checker.sv
// ----------------------------------------------------------------------------
// cfvs_checker
// Port-level checks on the request/result sequencing of the top level.
// ----------------------------------------------------------------------------
`include "clock_frame_victim_select_macros.svh"

module cfvs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       valid_o,
  input logic [4:0] victim_frame_o,
  input logic       found_o,
  input logic       write_back_o
);

  `CFVS_ASSERT(a_result_when_idle, valid_o |-> !busy, "result strobed while busy")
  `CFVS_ASSERT_NEXT(a_take_sets_busy, start && !busy, busy, "taken word did not raise busy")
  `CFVS_ASSERT(a_busy_ends_in_result, $fell(busy) |-> valid_o, "busy dropped without a result")
  `CFVS_ASSERT_NEXT(a_single_result, valid_o, !valid_o, "two results for one word")
  `CFVS_ASSERT(a_miss_is_zero, valid_o && !found_o |-> victim_frame_o == 5'd0 && !write_back_o, "miss carries nonzero fields")

endmodule

bind clock_frame_victim_select cfvs_checker u_cfvs_checker (.*);

// File: bench/tb_clock_frame_victim_select.sv
// ----------------------------------------------------------------------------
// tb_clock_frame_victim_select
// Self-checking bench for the clock frame victim selector. A directed table
// covers reset state, field extremes, every opcode, reserved-frame release,
// write-back on clean and unused opcodes; random phases then fill the frame
// table, run the hand through the free, clean-used and dirty-used sweeps
// down to the no-victim case, and mix in noise. Every result word is checked
// field by field against a typed row or an in-bench frame table and clock hand.
// ----------------------------------------------------------------------------
module tb_clock_frame_victim_select;

  localparam int unsigned NFRAMES      = 32;
  localparam int unsigned ITEMS_TARGET = 850;
  localparam int unsigned CALM_AFTER   = 760;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DIR_ROWS     = 22;

  localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

  typedef enum {SWP_FREE, SWP_CLEAN_USED, SWP_DIRTY_USED} sweep_e;

  typedef struct packed {
    logic [4:0] victim;
    logic       found;
    logic       wb;
  } outcome_t;

  typedef struct {
    logic [2:0] op;
    logic [4:0] fr;
    logic       wr;
    bit         typed;
    outcome_t   want;
  } stim_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  logic [2:0] opcode_i;
  logic [4:0] frame_i;
  logic       is_write_i;
  logic       valid_o;
  logic [4:0] victim_frame_o;
  logic       found_o;
  logic       write_back_o;

  clock_frame_victim_select #(
    .FRAMES(NFRAMES)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .opcode_i      (opcode_i),
    .frame_i       (frame_i),
    .is_write_i    (is_write_i),
    .valid_o       (valid_o),
    .victim_frame_o(victim_frame_o),
    .found_o       (found_o),
    .write_back_o  (write_back_o)
  );

  // frame table copy and hand
  cfvs_pkg::status_e tbl_status [NFRAMES];
  bit                tbl_owned  [NFRAMES];
  bit                tbl_use    [NFRAMES];
  bit                tbl_dirty  [NFRAMES];
  int unsigned       tbl_hand;

  outcome_t    pending_replies [$];
  int unsigned err_count;
  int unsigned words_sent;
  int unsigned stall_cycles;
  bit          idle_on;

  stim_row_t dir_rows [DIR_ROWS] = '{
    '{cfvs_pkg::OP_FIND,    5'd0,  1'b0, 1'b1, '{5'd1, 1'b1, 1'b0}},
    '{cfvs_pkg::OP_FIND,    5'd31, 1'b1, 1'b0, '0},
    '{cfvs_pkg::OP_RELEASE, 5'd1,  1'b0, 1'b1, '{5'd0, 1'b0, 1'b0}},
    '{cfvs_pkg::OP_FILL,    5'd31, 1'b0, 1'b1, '{5'd0, 1'b1, 1'b0}},
    '{cfvs_pkg::OP_ACCESS,  5'd31, 1'b1, 1'b1, '{5'd0, 1'b1, 1'b0}},
    '{cfvs_pkg::OP_CLEAN,   5'd31, 1'b0, 1'b1, '{5'd0, 1'b1, 1'b1}},
    '{cfvs_pkg::OP_CLEAN,   5'd31, 1'b0, 1'b1, '{5'd0, 1'b1, 1'b0}},
    '{cfvs_pkg::OP_ACCESS,  5'd0,  1'b0, 1'b1, '{5'd0, 1'b1, 1'b0}},
    '{cfvs_pkg::OP_CLEAN,   5'd0,  1'b1, 1'b1, '{5'd0, 1'b1, 1'b0}},
    '{OP_UNUSED_FIRST,      5'd31, 1'b1, 1'b1, '{5'd0, 1'b0, 1'b0}},
    '{OP_UNUSED_LAST,       5'd0,  1'b0, 1'b1, '{5'd0, 1'b0, 1'b0}},
    '{cfvs_pkg::OP_FILL,    5'd1,  1'b0, 1'b1, '{5'd0, 1'b1, 1'b0}},
    '{cfvs_pkg::OP_RELEASE, 5'd1,  1'b1, 1'b1, '{5'd0, 1'b1, 1'b0}},
    '{cfvs_pkg::OP_FIND,    5'd0,  1'b0, 1'b0, '0},
    '{cfvs_pkg::OP_FILL,    5'd21, 1'b1, 1'b0, '0},
    '{cfvs_pkg::OP_ACCESS,  5'd21, 1'b1, 1'b0, '0},
    '{cfvs_pkg::OP_FILL,    5'd10, 1'b0, 1'b0, '0},
    '{cfvs_pkg::OP_ACCESS,  5'd10, 1'b0, 1'b0, '0},
    '{cfvs_pkg::OP_FIND,    5'd10, 1'b1, 1'b0, '0},
    '{cfvs_pkg::OP_CLEAN,   5'd21, 1'b0, 1'b1, '{5'd0, 1'b1, 1'b1}},
    '{cfvs_pkg::OP_RELEASE, 5'd21, 1'b0, 1'b0, '0},
    '{cfvs_pkg::OP_RELEASE, 5'd31, 1'b0, 1'b0, '0}
  };

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // one sweep of NFRAMES+1 hand steps, skipping the origin frame
  function automatic int clock_sweep(input int unsigned origin, input sweep_e kind);
    int unsigned f;
    int          n;
    for (n = 0; n <= NFRAMES; n++) begin
      tbl_hand = (tbl_hand + 1) % NFRAMES;
      f = tbl_hand;
      if (f != origin) begin
        if (kind == SWP_FREE) begin
          if (tbl_status[f] == cfvs_pkg::ST_FREE) return int'(f);
        end else begin
          if (!tbl_owned[f]) return int'(f);
          if (tbl_status[f] != cfvs_pkg::ST_RESERVED && tbl_use[f]) begin
            if (kind == SWP_CLEAN_USED && !tbl_dirty[f]) return int'(f);
            if (kind == SWP_DIRTY_USED && tbl_dirty[f]) return int'(f);
          end
          if (kind == SWP_DIRTY_USED) tbl_use[f] = 1'b1;
        end
      end
    end
    return -1;
  endfunction

  function automatic outcome_t table_command(input logic [2:0] op, input logic [4:0] fr,
                                             input logic wr);
    outcome_t    r;
    int unsigned origin;
    int          v;
    int          pass;
    r = '0;
    case (op)
      cfvs_pkg::OP_FIND: begin
        origin = tbl_hand;
        v = clock_sweep(origin, SWP_FREE);
        for (pass = 0; v < 0 && pass < 2; pass++) begin
          v = clock_sweep(origin, SWP_CLEAN_USED);
          if (v < 0) v = clock_sweep(origin, SWP_DIRTY_USED);
        end
        if (v >= 0) begin
          r.victim = v[4:0];
          r.found  = 1'b1;
          r.wb     = tbl_owned[v] && tbl_dirty[v];
          tbl_status[v] = cfvs_pkg::ST_RESERVED;
        end
      end
      cfvs_pkg::OP_ACCESS: begin
        tbl_use[fr] = 1'b0;
        if (wr) tbl_dirty[fr] = 1'b1;
        r.found = 1'b1;
      end
      cfvs_pkg::OP_FILL: begin
        tbl_status[fr] = cfvs_pkg::ST_INUSE;
        tbl_owned[fr]  = 1'b1;
        tbl_use[fr]    = 1'b0;
        tbl_dirty[fr]  = 1'b0;
        r.found = 1'b1;
      end
      cfvs_pkg::OP_RELEASE: begin
        if (tbl_status[fr] != cfvs_pkg::ST_RESERVED) begin
          tbl_status[fr] = cfvs_pkg::ST_FREE;
          tbl_owned[fr]  = 1'b0;
          tbl_use[fr]    = 1'b0;
          tbl_dirty[fr]  = 1'b0;
          r.found = 1'b1;
        end
      end
      cfvs_pkg::OP_CLEAN: begin
        r.wb = tbl_owned[fr] && tbl_dirty[fr];
        tbl_dirty[fr] = 1'b0;
        r.found = 1'b1;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic issue_word(input logic [2:0] op, input logic [4:0] fr, input logic wr,
                            input bit typed, input outcome_t typed_want);
    outcome_t pred;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start      <= 1'b1;
    opcode_i   <= op;
    frame_i    <= fr;
    is_write_i <= wr;
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    pred = table_command(op, fr, wr);
    pending_replies.push_back(typed ? typed_want : pred);
    @(posedge clk_i);
    words_sent++;
  endtask

  task automatic rand_word(input logic [2:0] op);
    issue_word(op, 5'($urandom_range(0, NFRAMES - 1)), 1'($urandom_range(0, 1)), 1'b0, '0);
  endtask

  task automatic await_replies();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_replies.size() != 0);
  endtask

  // result words, sampled mid-cycle
  always @(negedge clk_i) begin
    outcome_t want;
    if (rst_ni && valid_o) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected word: victim_frame=%0d found=%0d write_back=%0d",
               victim_frame_o, found_o, write_back_o);
        err_count++;
      end else begin
        want = pending_replies.pop_front();
        if (victim_frame_o !== want.victim) begin
          $error("victim_frame: expected %0d, got %0d", want.victim, victim_frame_o);
          err_count++;
        end
        if (found_o !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, found_o);
          err_count++;
        end
        if (write_back_o !== want.wb) begin
          $error("write_back: expected %0d, got %0d", want.wb, write_back_o);
          err_count++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni || valid_o || (start && !busy)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int          i;
    int          k;
    int          n;
    int unsigned base;
    int unsigned pick;
    rst_ni       = 1'b0;
    start        = 1'b0;
    opcode_i     = cfvs_pkg::OP_FIND;
    frame_i      = '0;
    is_write_i   = 1'b0;
    err_count    = 0;
    words_sent   = 0;
    stall_cycles = 0;
    idle_on      = 1'b1;
    tbl_hand     = 0;
    for (i = 0; i < NFRAMES; i++) begin
      tbl_status[i] = cfvs_pkg::ST_FREE;
      tbl_owned[i]  = 1'b0;
      tbl_use[i]    = 1'b0;
      tbl_dirty[i]  = 1'b0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < DIR_ROWS; i++)
      issue_word(dir_rows[i].op, dir_rows[i].fr, dir_rows[i].wr, dir_rows[i].typed,
                 dir_rows[i].want);
    await_replies();

    while (words_sent < ITEMS_TARGET) begin
      idle_on = (words_sent < CALM_AFTER) && ($urandom_range(0, 2) != 0);
      if ((words_sent < CALM_AFTER) && ($urandom_range(0, 3) == 0)) await_replies();
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        // populate the whole table, then work it
        base = $urandom_range(0, NFRAMES - 1);
        for (i = 0; i < NFRAMES; i++)
          issue_word(cfvs_pkg::OP_FILL, 5'((base + i) % NFRAMES), 1'($urandom_range(0, 1)),
                     1'b0, '0);
        if (pick <= 3) begin
          n = $urandom_range(20, 60);
          for (k = 0; k < n; k++) begin
            case ($urandom_range(0, 19))
              0, 1, 2, 3, 4, 5, 6, 7, 8, 9: rand_word(cfvs_pkg::OP_FIND);
              10, 11, 12, 13, 14, 15:       rand_word(cfvs_pkg::OP_ACCESS);
              16, 17:                       rand_word(cfvs_pkg::OP_CLEAN);
              18:                           rand_word(cfvs_pkg::OP_FILL);
              default:                      rand_word(cfvs_pkg::OP_RELEASE);
            endcase
          end
        end else begin
          // run a burst of mostly finds to wear the table down toward exhaustion
          for (k = 0; k < 36; k++) begin
            if ($urandom_range(0, 4) == 0) rand_word(cfvs_pkg::OP_ACCESS);
            else rand_word(cfvs_pkg::OP_FIND);
          end
        end
      end else if (pick <= 7) begin
        n = $urandom_range(8, 16);
        for (k = 0; k < n; k++) begin
          case ($urandom_range(0, 3))
            0:       rand_word(cfvs_pkg::OP_RELEASE);
            1:       rand_word(cfvs_pkg::OP_FILL);
            default: rand_word(cfvs_pkg::OP_FIND);
          endcase
        end
      end else begin
        n = $urandom_range(10, 20);
        for (k = 0; k < n; k++)
          rand_word(3'($urandom_range(cfvs_pkg::OP_FIND, OP_UNUSED_LAST)));
      end
    end

    await_replies();
    repeat (8) @(posedge clk_i);
    if (err_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
